@@ src/orb_pkg.sv @@
package orb_pkg;

  localparam int unsigned Depth    = 64;
  localparam int unsigned ElemBits = 8;
  localparam int unsigned IdxW     = $clog2(Depth);
  localparam int unsigned CntW     = $clog2(Depth + 1);
  localparam int unsigned OpW      = 2;
  localparam int unsigned ReqW     = 7;
  localparam int unsigned CapW     = 7;

  typedef enum logic [OpW-1:0] {
    OP_PUT       = 2'd0,
    OP_GET       = 2'd1,
    OP_GET_BLOCK = 2'd2,
    OP_NONE      = 2'd3
  } op_e;

  typedef struct packed {
    logic [OpW-1:0]      opcode;
    logic [ElemBits-1:0] write_data;
    logic [ReqW-1:0]     block_count;
  } in_word_t;

  typedef struct packed {
    logic [ElemBits-1:0] read_data;
    logic                has_data;
    logic                status;
    logic [CntW-1:0]     fill_count;
    logic                last;
  } out_word_t;

  typedef struct packed {
    logic accept;
    logic issue_read;
    logic load_fetch;
    logic cfg_write;
  } orb_cmd_t;

  typedef struct packed {
    logic item_reads;
    logic more;
  } orb_status_t;

endpackage

@@ src/orb_datapath.sv @@
module orb_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  orb_pkg::orb_cmd_t               cmd_i,
  output orb_pkg::orb_status_t            status_o,
  input  orb_pkg::in_word_t               in_data_i,
  input  logic [orb_pkg::CapW-1:0]        cfg_data_i,
  output orb_pkg::out_word_t              out_data_o
);
  import orb_pkg::*;

  logic [ElemBits-1:0] mem [Depth];
  logic [ElemBits-1:0] rdata_q;

  logic [IdxW-1:0] wr_idx_q, wr_idx_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CapW-1:0] cap_q, cap_d;
  logic [ReqW-1:0] rem_q, rem_d;
  out_word_t       out_q;

  logic [CntW-1:0] cnt_inc;
  logic [ReqW-1:0] take_n;
  logic            is_put;
  logic            is_get;
  logic            is_blk;
  logic            mem_we;

  function automatic logic [IdxW-1:0] next_idx(logic [IdxW-1:0] idx, logic [CapW-1:0] cap);
    logic [IdxW:0] n;
    n = {1'b0, idx} + {{IdxW{1'b0}}, 1'b1};
    next_idx = (CapW'(n) >= cap) ? '0 : n[IdxW-1:0];
  endfunction

  assign is_put = (op_e'(in_data_i.opcode) == OP_PUT);
  assign is_get = (op_e'(in_data_i.opcode) == OP_GET);
  assign is_blk = (op_e'(in_data_i.opcode) == OP_GET_BLOCK);

  assign status_o.item_reads = (cnt_q != '0) &&
                               (is_get || (is_blk && in_data_i.block_count != '0));
  assign status_o.more       = (rem_q != '0);

  assign cnt_inc = cnt_q + CntW'(1);
  assign take_n  = !is_blk ? ReqW'(1) :
                   (in_data_i.block_count < ReqW'(cnt_q)) ? in_data_i.block_count : ReqW'(cnt_q);
  assign mem_we  = cmd_i.accept && is_put;

  always_comb begin
    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    cnt_d    = cnt_q;
    cap_d    = cap_q;
    rem_d    = rem_q;
    if (cmd_i.cfg_write) begin
      if (cfg_data_i != '0) begin
        cap_d    = (cfg_data_i > CapW'(Depth)) ? CapW'(Depth) : cfg_data_i;
        wr_idx_d = '0;
        rd_idx_d = '0;
        cnt_d    = '0;
      end
    end else if (mem_we) begin
      wr_idx_d = next_idx(wr_idx_q, cap_q);
      if (CapW'(cnt_inc) >= cap_q) begin
        // Full: the oldest word is overwritten, so reading restarts behind the writer.
        cnt_d    = CntW'(cap_q);
        rd_idx_d = wr_idx_d;
      end else begin
        cnt_d = cnt_inc;
      end
    end else if (cmd_i.issue_read) begin
      rd_idx_d = next_idx(rd_idx_q, cap_q);
      cnt_d    = cnt_q - CntW'(1);
    end
    if (cmd_i.accept) begin
      // Words that read nothing leave no further reads pending.
      rem_d = status_o.item_reads ? (take_n - ReqW'(1)) : '0;
    end else if (cmd_i.issue_read) begin
      rem_d = rem_q - ReqW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      cnt_q    <= '0;
      cap_q    <= CapW'(Depth);
      rem_q    <= '0;
    end else begin
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
      cnt_q    <= cnt_d;
      cap_q    <= cap_d;
      rem_q    <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_idx_q] <= in_data_i.write_data;
    end
    if (cmd_i.issue_read) begin
      rdata_q <= mem[rd_idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && !status_o.item_reads) begin
      out_q.read_data  <= '0;
      out_q.has_data   <= 1'b0;
      out_q.status     <= (cnt_q == '0) &&
                          (is_get || (is_blk && in_data_i.block_count != '0));
      out_q.fill_count <= cnt_d;
      out_q.last       <= 1'b1;
    end else if (cmd_i.load_fetch) begin
      out_q.read_data  <= rdata_q;
      out_q.has_data   <= 1'b1;
      out_q.status     <= 1'b0;
      out_q.fill_count <= cnt_q;
      out_q.last       <= (rem_q == '0);
    end
  end

  assign out_data_o = out_q;

  a_cnt_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CapW'(cnt_q) <= cap_q)
    else $error("fill count exceeds capacity");

  a_cap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cap_q != '0) && (cap_q <= CapW'(Depth)))
    else $error("capacity out of range");

  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue_read |-> (cnt_q != '0))
    else $error("read issued on empty buffer");

  a_full_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CapW'(cnt_q) == cap_q) |-> (wr_idx_q == rd_idx_q))
    else $error("full buffer with split pointers");

endmodule

@@ src/orb_controller.sv @@
module orb_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  orb_pkg::orb_status_t status_i,
  output orb_pkg::orb_cmd_t    cmd_o
);
  import orb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_EMIT  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   in_acc;
  logic   out_acc;

  assign in_stall_o  = (state_q != S_IDLE) || cfg_valid_i;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_EMIT);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;

  always_comb begin
    cmd_o.accept     = in_acc;
    cmd_o.cfg_write  = cfg_valid_i && cfg_ready_o;
    cmd_o.load_fetch = (state_q == S_FETCH);
    cmd_o.issue_read = (in_acc && status_i.item_reads) || (out_acc && status_i.more);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = status_i.item_reads ? S_FETCH : S_EMIT;
        end
      end
      S_FETCH: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_acc) begin
          state_d = status_i.more ? S_FETCH : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_fetch_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FETCH) |=> (state_q == S_EMIT))
    else $error("fetch not followed by output");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !cmd_o.cfg_write)
    else $error("word accepted together with a configuration write");

  a_read_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue_read |=> (state_q == S_FETCH))
    else $error("memory read without fetch state");

endmodule

@@ src/overwriting_ring_buffer.sv @@
// Overwriting ring buffer of 8-bit words with a configurable capacity.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries an opcode: put
// stores a word, get takes the oldest word, get block takes up to
// block_count words. Output channel (out_valid_o / out_stall_i / out_data_o)
// returns one word per result with the fill count after that result; the
// final result of each input word has last set.
// The configuration channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes
// the capacity, which empties the buffer; zero is ignored, values above 64
// saturate. It is taken only while no input word is in progress.
// One input word is handled at a time. A put, or any word that reads
// nothing, shows its result in the cycle after acceptance. Each get
// result passes the registered memory port and then, in the fetch state,
// the output register; a block get reads each further word only once the
// previous result is taken. A new input word is accepted in idle, after the
// last result is taken. A stalled result simply holds in the output register.
// Reset empties the buffer and sets the capacity to 64; no clearing pass is
// needed, since only written slots are ever read.
module overwriting_ring_buffer (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  orb_pkg::in_word_t        in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output orb_pkg::out_word_t       out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [orb_pkg::CapW-1:0] cfg_data_i
);
  import orb_pkg::*;

  orb_cmd_t    cmd;
  orb_status_t status;

  orb_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  orb_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .status_o  (status),
    .in_data_i (in_data_i),
    .cfg_data_i(cfg_data_i),
    .out_data_o(out_data_o)
  );

endmodule
